### hdl/assert_macros.svh
// Assertion macros shared by the tile renderer modules.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, with the reset held off.
`define TBWP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tile renderer check failed");
// Next-cycle implication, with the reset held off.
`define TBWP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tile renderer check failed");
`else
`define TBWP_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TBWP_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

### hdl/tbwp_pkg.sv
// Package for the tile renderer: word types, opcodes, register indexes and constants.
// Depends on nothing; the top level and the result queue use it by scoped names.
`timescale 1ns / 1ps

package tbwp_pkg;

	// Video memory geometry: two byte-wide banks, even and odd addresses.
	localparam int VIDEO_BYTES = 8192;
	localparam int VRAM_AW     = $clog2(VIDEO_BYTES);
	localparam int BANK_DEPTH  = VIDEO_BYTES / 2;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);

	// Screen and window limits.
	localparam int SCREEN_WIDTH    = 160;
	localparam int WINDOW_X_LIMIT  = 166;
	localparam int WINDOW_X_OFFSET = 7;

	// Tile map bases.
	localparam logic [VRAM_AW-1:0] MAP_LOW  = 13'h1800;
	localparam logic [VRAM_AW-1:0] MAP_HIGH = 13'h1C00;

	// Control register bits.
	localparam int LCDC_BG_ON       = 0;
	localparam int LCDC_BG_MAP_HIGH = 3;
	localparam int LCDC_UNSIGNED    = 4;
	localparam int LCDC_WIN_ON      = 5;
	localparam int LCDC_WIN_MAP     = 6;

	// Reset colours.
	localparam logic [15:0] SHADE0_RESET = 16'd48433;
	localparam logic [15:0] SHADE1_RESET = 16'd37867;
	localparam logic [15:0] SHADE2_RESET = 16'd25222;
	localparam logic [15:0] SHADE3_RESET = 16'd8386;

	// Result queue.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	localparam int OCC_W      = FIFO_CW + 1;

	// Configuration register width and index.
	localparam int CFG_DW = 16;

	typedef enum logic [2:0] {
		CFG_LCD_CONTROL = 3'd0,
		CFG_SCROLL_X    = 3'd1,
		CFG_SCROLL_Y    = 3'd2,
		CFG_WINDOW_X    = 3'd3,
		CFG_WINDOW_Y    = 3'd4,
		CFG_SHADE0      = 3'd5,
		CFG_SHADE1      = 3'd6,
		CFG_SHADE2      = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_VRAM_WRITE = 2'd0,
		OP_RENDER     = 2'd1,
		OP_SHADE3     = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [VRAM_AW-1:0] vram_address;
		logic [15:0]        write_data;
		logic [7:0]         line;
		logic [7:0]         column;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  shade_index;
		logic [15:0] pixel_color;
		logic        from_window;
		logic        drawn;
	} out_word_t;

endpackage

### hdl/tbwp_ram.sv
// Generic synchronous RAM: one write port and two read ports, read data registered.
// Depends on nothing; a read at the address being written returns the old contents.
`timescale 1ns / 1ps

module tbwp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] a_addr,
	output logic [WIDTH-1:0]         a_data,
	input  logic [$clog2(DEPTH)-1:0] b_addr,
	output logic [WIDTH-1:0]         b_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Storage array with read-before-write behaviour on both read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		a_data <= mem[a_addr];
		b_data <= mem[b_addr];
	end

endmodule

### hdl/tbwp_out_fifo.sv
// Small result queue that decouples the render pipeline from the output handshake.
// Depends on tbwp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbwp_out_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  tbwp_pkg::out_word_t         push_word,
	output logic                        valid,
	input  logic                        ready,
	output tbwp_pkg::out_word_t         word,
	output logic [tbwp_pkg::FIFO_CW-1:0] count
);

	tbwp_pkg::out_word_t              words_q [tbwp_pkg::FIFO_DEPTH];
	logic [tbwp_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [tbwp_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [tbwp_pkg::FIFO_CW-1:0]     count_q;
	logic                             pop;

	assign valid = (count_q != '0);
	assign pop   = valid && ready;
	assign word  = words_q[rd_ptr_q];
	assign count = count_q;

	// Entry storage; no reset needed for the payload.
	always_ff @(posedge clk) begin
		if (push) begin
			words_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The credit check upstream must keep a free entry for every push.
	`TBWP_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, count_q != tbwp_pkg::FIFO_CW'(tbwp_pkg::FIFO_DEPTH))
	`TBWP_ASSERT_NEXT(a_count_hold, clk, arst_n, !push && !pop, $stable(count_q))
	`TBWP_ASSERT_NEXT(a_count_rise, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

### hdl/tile_background_window_pixel.sv
// Top level of the background and window tile renderer.
// Depends on tbwp_pkg, tbwp_ram, tbwp_out_fifo and assert_macros.svh.
//
//  Channel   Signals                               Moves
//  input     in_valid, in_ready, in_word           one command word per handshake
//  output    out_valid, out_ready, out_word        one pixel word per render command
//  config    cfg_write_en, cfg_index, cfg_data     one register write per enabled cycle
//
// One word is accepted per cycle while in_ready is high. A render word reads its map
// entry in the cycle of acceptance and its tile row in the next cycle, both from the
// banked video memory, and stage 2 pushes its pixel into the four-entry result queue.
// After reset the video memory is cleared one 16-bit row a cycle, all 4096 rows of it,
// during which no word is accepted. A stalled output only holds off new input once the
// result queue and the two pipeline stages together hold four pixels.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tile_background_window_pixel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tbwp_pkg::in_word_t            in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output tbwp_pkg::out_word_t           out_word,
	input  logic                          cfg_write_en,
	input  logic [2:0]                    cfg_index,
	input  logic [tbwp_pkg::CFG_DW-1:0]   cfg_data
);

	localparam int BAW = tbwp_pkg::BANK_AW;

	// Configuration registers and the shade 3 colour.
	logic [7:0]  lcd_control_q, scroll_x_q, scroll_y_q, window_x_q, window_y_q;
	logic [15:0] shade0_q, shade1_q, shade2_q, shade3_q;

	// Clearing pass.
	logic [BAW:0] clr_q;
	logic         clearing;

	// Stage 0 decode.
	logic         accept, acc_write, acc_render, acc_shade3;
	logic         on_screen, win_hit, bg_hit;
	logic [7:0]   x0, wl, wc, sy, sx;
	logic [9:0]   map_ent;
	logic         map_high;
	logic [tbwp_pkg::VRAM_AW-1:0] map_addr;
	logic [2:0]   row_s0, bit_s0;

	// Memory ports.
	logic           we_even, we_odd;
	logic [BAW-1:0] wr_addr;
	logic [7:0]     wr_data;
	logic [BAW-1:0] map_word;
	logic [BAW-1:0] tile_word;
	logic [7:0]     even_a, odd_a, even_b, odd_b;

	// Stage 1.
	logic         v_s1, drawn_s1, win_s1, bank_s1;
	logic [2:0]   row_s1, bit_s1;
	logic [15:0]  shade3_s1;
	logic [7:0]   tile_num;
	logic [8:0]   tile_idx;

	// Stage 2.
	logic         v_s2, drawn_s2, win_s2;
	logic [2:0]   bit_s2;
	logic [15:0]  shade3_s2;
	logic [2:0]   bit_sel;
	logic [1:0]   shade;
	tbwp_pkg::out_word_t push_word;

	// Result queue and credit.
	logic [tbwp_pkg::FIFO_CW-1:0] fifo_count;
	logic [tbwp_pkg::OCC_W-1:0]   occupancy;

	// Handshake and credit: room for every pixel already in flight.
	assign clearing  = ~clr_q[BAW];
	assign occupancy = tbwp_pkg::OCC_W'(fifo_count) + tbwp_pkg::OCC_W'(v_s1)
		+ tbwp_pkg::OCC_W'(v_s2);
	assign in_ready  = !clearing && (occupancy < tbwp_pkg::OCC_W'(tbwp_pkg::FIFO_DEPTH));
	assign accept    = in_valid && in_ready;
	assign acc_write  = accept && (in_word.opcode == tbwp_pkg::OP_VRAM_WRITE);
	assign acc_render = accept && (in_word.opcode == tbwp_pkg::OP_RENDER);
	assign acc_shade3 = accept && (in_word.opcode == tbwp_pkg::OP_SHADE3);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcd_control_q <= '0;
			scroll_x_q    <= '0;
			scroll_y_q    <= '0;
			window_x_q    <= '0;
			window_y_q    <= '0;
			shade0_q      <= tbwp_pkg::SHADE0_RESET;
			shade1_q      <= tbwp_pkg::SHADE1_RESET;
			shade2_q      <= tbwp_pkg::SHADE2_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				tbwp_pkg::CFG_LCD_CONTROL: lcd_control_q <= cfg_data[7:0];
				tbwp_pkg::CFG_SCROLL_X:    scroll_x_q    <= cfg_data[7:0];
				tbwp_pkg::CFG_SCROLL_Y:    scroll_y_q    <= cfg_data[7:0];
				tbwp_pkg::CFG_WINDOW_X:    window_x_q    <= cfg_data[7:0];
				tbwp_pkg::CFG_WINDOW_Y:    window_y_q    <= cfg_data[7:0];
				tbwp_pkg::CFG_SHADE0:      shade0_q      <= cfg_data;
				tbwp_pkg::CFG_SHADE1:      shade1_q      <= cfg_data;
				tbwp_pkg::CFG_SHADE2:      shade2_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shade 3 colour, set by a command word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shade3_q <= tbwp_pkg::SHADE3_RESET;
		end else if (acc_shade3) begin
			shade3_q <= in_word.write_data;
		end
	end

	// Clearing pass counter: one row of both banks per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Stage 0: choose the layer and form the map address.
	always_comb begin
		on_screen = ({1'b0, in_word.column} < 9'(tbwp_pkg::SCREEN_WIDTH));
		x0 = (window_x_q >= 8'(tbwp_pkg::WINDOW_X_OFFSET))
			? window_x_q - 8'(tbwp_pkg::WINDOW_X_OFFSET) : 8'd0;
		wl = in_word.line - window_y_q;
		wc = in_word.column - x0;
		sy = scroll_y_q + in_word.line;
		sx = scroll_x_q + in_word.column;
		win_hit = on_screen && lcd_control_q[tbwp_pkg::LCDC_WIN_ON]
			&& (window_x_q < 8'(tbwp_pkg::WINDOW_X_LIMIT))
			&& (in_word.line >= window_y_q) && (in_word.column >= x0);
		bg_hit = on_screen && !win_hit && lcd_control_q[tbwp_pkg::LCDC_BG_ON];
		if (win_hit) begin
			map_ent  = {wl[7:3], wc[7:3]};
			map_high = lcd_control_q[tbwp_pkg::LCDC_WIN_MAP];
			row_s0   = wl[2:0];
			bit_s0   = wc[2:0];
		end else begin
			map_ent  = {sy[7:3], sx[7:3]};
			map_high = lcd_control_q[tbwp_pkg::LCDC_BG_MAP_HIGH];
			row_s0   = sy[2:0];
			bit_s0   = sx[2:0];
		end
		map_addr = (map_high ? tbwp_pkg::MAP_HIGH : tbwp_pkg::MAP_LOW)
			| tbwp_pkg::VRAM_AW'(map_ent);
		map_word = map_addr[tbwp_pkg::VRAM_AW-1:1];
	end

	// Write port: the clearing pass, else a write command to one bank.
	always_comb begin
		if (clearing) begin
			we_even = 1'b1;
			we_odd  = 1'b1;
			wr_addr = clr_q[BAW-1:0];
			wr_data = 8'd0;
		end else begin
			we_even = acc_write && !in_word.vram_address[0];
			we_odd  = acc_write && in_word.vram_address[0];
			wr_addr = in_word.vram_address[tbwp_pkg::VRAM_AW-1:1];
			wr_data = in_word.write_data[7:0];
		end
	end

	tbwp_ram #(
		.WIDTH(8),
		.DEPTH(tbwp_pkg::BANK_DEPTH)
	) u_even (
		.clk     (clk),
		.wr_en   (we_even),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.a_addr  (map_word),
		.a_data  (even_a),
		.b_addr  (tile_word),
		.b_data  (even_b)
	);

	tbwp_ram #(
		.WIDTH(8),
		.DEPTH(tbwp_pkg::BANK_DEPTH)
	) u_odd (
		.clk     (clk),
		.wr_en   (we_odd),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.a_addr  (map_word),
		.a_data  (odd_a),
		.b_addr  (tile_word),
		.b_data  (odd_b)
	);

	// Stage 1 registers: valid with reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc_render;
		end
	end

	always_ff @(posedge clk) begin
		drawn_s1  <= win_hit || bg_hit;
		win_s1    <= win_hit;
		bank_s1   <= map_addr[0];
		row_s1    <= row_s0;
		bit_s1    <= bit_s0;
		shade3_s1 <= shade3_q;
	end

	// Stage 1: tile number to tile row address. Signed numbering is based at tile 256,
	// so numbers below 0x80 land in the upper half of the pattern area.
	always_comb begin
		tile_num  = bank_s1 ? odd_a : even_a;
		tile_idx  = {~lcd_control_q[tbwp_pkg::LCDC_UNSIGNED] & ~tile_num[7], tile_num};
		tile_word = {tile_idx, row_s1};
	end

	// Stage 2 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		drawn_s2  <= drawn_s1;
		win_s2    <= win_s1;
		bit_s2    <= bit_s1;
		shade3_s2 <= shade3_s1;
	end

	// Stage 2: pick the pixel bits and its colour. The leftmost pixel is bit 7.
	always_comb begin
		bit_sel = ~bit_s2;
		shade   = drawn_s2 ? {odd_b[bit_sel], even_b[bit_sel]} : 2'd0;
		push_word.shade_index = shade;
		push_word.from_window = win_s2;
		push_word.drawn       = drawn_s2;
		if (!drawn_s2) begin
			push_word.pixel_color = 16'd0;
		end else begin
			case (shade)
				2'd0:    push_word.pixel_color = shade0_q;
				2'd1:    push_word.pixel_color = shade1_q;
				2'd2:    push_word.pixel_color = shade2_q;
				default: push_word.pixel_color = shade3_s2;
			endcase
		end
	end

	tbwp_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_word (push_word),
		.valid     (out_valid),
		.ready     (out_ready),
		.word      (out_word),
		.count     (fifo_count)
	);

	// Pipeline and credit checks.
	`TBWP_ASSERT_IMPL(a_credit_bound, clk, arst_n, 1'b1, occupancy <= tbwp_pkg::OCC_W'(tbwp_pkg::FIFO_DEPTH))
	`TBWP_ASSERT_NEXT(a_render_enters, clk, arst_n, acc_render, v_s1 && v_s2 == $past(v_s1))
	`TBWP_ASSERT_IMPL(a_window_drawn, clk, arst_n, v_s2 && win_s2, drawn_s2)
	`TBWP_ASSERT_IMPL(a_blank_zero, clk, arst_n, v_s2 && !drawn_s2, push_word.pixel_color == 16'd0 && push_word.shade_index == 2'd0)

endmodule

### verif/tb_tile_background_window_pixel.sv
// Self-checking testbench for the background and window tile renderer.
// Depends on tbwp_pkg and tile_background_window_pixel; pixel words are checked
// against a behavioural model of the video memory, registers and layer rules.
`timescale 1ns / 1ps

module tb_tile_background_window_pixel;
	import tbwp_pkg::*;

	localparam int CLK_HALF_NS   = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES        = 6;
	localparam int PHASE_WORDS   = 335;
	localparam int PRESSURE_PHASE = 4;
	localparam int LONG_HOLD     = 400;
	localparam int RUN_LIMIT_NS  = 8_000_000;

	// The fourth opcode is not decoded; the block drops such words.
	localparam logic [1:0] OP_IGNORED = 2'd3;

	// Idle percentages of the sender and the receiver, per random phase.
	localparam int SEND_IDLE [PHASES]  = '{0, 74, 0, 28, 0, 28};
	localparam int RECV_STALL [PHASES] = '{0, 0, 74, 28, 0, 28};

	// Tile numbers that map writes favour, and the pattern bases of those tiles
	// under both unsigned and signed addressing.
	localparam logic [7:0] HOT_TILES [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
	localparam logic [12:0] HOT_PATTERNS [8] = '{13'h0000, 13'h0010, 13'h07F0, 13'h0800,
		13'h0FF0, 13'h1000, 13'h1010, 13'h17F0};

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		in_word_t  word;
		cfg_idx_t  reg_idx;
		logic [15:0] reg_val;
		logic      typed;
		out_word_t want;
	} directed_row_t;

	localparam out_word_t BLANK   = '0;
	localparam in_word_t  NO_WORD = '0;
	localparam cfg_idx_t  NO_IDX  = CFG_LCD_CONTROL;
	localparam int DIRECTED_ROWS  = 38;

	// Directed stimulus: register rows are applied with the block idle.
	localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd0, 8'd0}, NO_IDX, 16'h0, 1'b1, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h1FFF, 16'hFFFF, 8'd255, 8'd255}, NO_IDX, 16'h0, 1'b1,
			BLANK},
		'{ROW_WORD, '{OP_VRAM_WRITE, 13'h1800, 16'h0001, 8'd0, 8'd0}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_VRAM_WRITE, 13'h0010, 16'h0080, 8'd0, 8'd0}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_VRAM_WRITE, 13'h0011, 16'h00FF, 8'd0, 8'd0}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_VRAM_WRITE, 13'h1FFF, 16'hFFFF, 8'd0, 8'd0}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_SHADE3, 13'h0000, 16'hFFFF, 8'd0, 8'd0}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_IGNORED, 13'h1FFF, 16'hFFFF, 8'd255, 8'd255}, NO_IDX, 16'h0, 1'b0,
			BLANK},
		'{ROW_WORD, '{OP_VRAM_WRITE, 13'h1010, 16'h00AA, 8'd0, 8'd0}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_VRAM_WRITE, 13'h0800, 16'h003C, 8'd0, 8'd0}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_LCD_CONTROL, 16'h0011, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd0, 8'd0}, NO_IDX, 16'h0, 1'b1,
			'{2'd3, 16'hFFFF, 1'b0, 1'b1}},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd0, 8'd1}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd143, 8'd159}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd0, 8'd160}, NO_IDX, 16'h0, 1'b1, BLANK},
		'{ROW_REG, NO_WORD, CFG_LCD_CONTROL, 16'h0001, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_SCROLL_X, 16'h00FF, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_SCROLL_Y, 16'h00FF, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd255, 8'd0}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd1, 8'd1}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_LCD_CONTROL, 16'h0061, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_WINDOW_X, 16'h0003, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_WINDOW_Y, 16'h0000, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd0, 8'd0}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd255, 8'd159}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_WINDOW_X, 16'd166, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd10, 8'd10}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_LCD_CONTROL, 16'h0020, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_WINDOW_X, 16'd165, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_WINDOW_Y, 16'd143, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_SHADE0, 16'h0000, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_SHADE1, 16'hFFFF, 1'b0, BLANK},
		'{ROW_REG, NO_WORD, CFG_SHADE2, 16'h0000, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd142, 8'd159}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd143, 8'd158}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd143, 8'd157}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_SHADE3, 13'h0000, 16'h0000, 8'd0, 8'd0}, NO_IDX, 16'h0, 1'b0, BLANK},
		'{ROW_WORD, '{OP_RENDER, 13'h0000, 16'h0000, 8'd143, 8'd159}, NO_IDX, 16'h0, 1'b0, BLANK}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_word;
	logic cfg_write_en = 1'b0;
	logic [2:0] cfg_index = 3'd0;
	logic [CFG_DW-1:0] cfg_data = '0;

	// Shadow of the block's state, kept in step with every accepted word.
	logic [7:0] vram_copy [VIDEO_BYTES] = '{default: 8'h00};
	logic [15:0] shade_rgb [4] = '{SHADE0_RESET, SHADE1_RESET, SHADE2_RESET, SHADE3_RESET};
	logic [7:0] lcd_ctl = 8'h00;
	logic [7:0] scroll_h = 8'h00;
	logic [7:0] scroll_v = 8'h00;
	logic [7:0] win_left = 8'h00;
	logic [7:0] win_top = 8'h00;

	out_word_t pending_pixels [$];
	int failures = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;

	tile_background_window_pixel dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_word      (in_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_word     (out_word),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial forever #CLK_HALF_NS clk = ~clk;

	// Two-bit shade of one pixel of the tile named by a map entry.
	function automatic logic [1:0] tile_pixel(input logic [12:0] entry_addr, input int row,
			input int col);
		logic [7:0] num;
		int tile;
		logic [12:0] pattern;
		int bitpos;
		num = vram_copy[entry_addr];
		// Signed numbering puts tile 0 at pattern 256.
		tile = lcd_ctl[LCDC_UNSIGNED] ? int'(num) : 256 + int'($signed(num));
		pattern = 13'((tile << 4) + ((row & 7) << 1));
		bitpos = 7 - (col & 7);
		return {vram_copy[pattern + 13'd1][bitpos], vram_copy[pattern][bitpos]};
	endfunction

	// Pixel word for one screen position under the current registers.
	function automatic out_word_t render_pixel(input logic [7:0] line, input logic [7:0] column);
		out_word_t px;
		int x0;
		int wl;
		int wc;
		int sy;
		int sx;
		logic [12:0] entry;
		px = '0;
		x0 = (win_left >= WINDOW_X_OFFSET) ? int'(win_left) - WINDOW_X_OFFSET : 0;
		if (int'(column) < SCREEN_WIDTH) begin
			if (lcd_ctl[LCDC_WIN_ON] && int'(win_left) < WINDOW_X_LIMIT &&
					line >= win_top && int'(column) >= x0) begin
				// The window is not scrolled and starts at its own column 0.
				wl = int'(line) - int'(win_top);
				wc = int'(column) - x0;
				entry = (lcd_ctl[LCDC_WIN_MAP] ? MAP_HIGH : MAP_LOW) +
					13'((((wl >> 3) << 5) + ((wc >> 3) & 31)) & 'h3FF);
				px.shade_index = tile_pixel(entry, wl, wc);
				px.from_window = 1'b1;
				px.drawn = 1'b1;
			end else if (lcd_ctl[LCDC_BG_ON]) begin
				// The scrolled line wraps to eight bits through the mask on the map row offset.
				sy = int'(scroll_v) + int'(line);
				sx = int'(scroll_h) + int'(column);
				entry = (lcd_ctl[LCDC_BG_MAP_HIGH] ? MAP_HIGH : MAP_LOW) +
					13'((((sy >> 3) << 5) & 'h3FF) + ((sx >> 3) & 31));
				px.shade_index = tile_pixel(entry, sy, sx);
				px.drawn = 1'b1;
			end
		end
		if (px.drawn)
			px.pixel_color = shade_rgb[px.shade_index];
		return px;
	endfunction

	// Updates the shadow state for one accepted word; true when it yields a pixel.
	function automatic logic apply_word(input in_word_t w, output out_word_t px);
		px = '0;
		if (w.opcode == OP_VRAM_WRITE)
			vram_copy[w.vram_address] = w.write_data[7:0];
		else if (w.opcode == OP_SHADE3)
			shade_rgb[3] = w.write_data;
		else if (w.opcode == OP_RENDER)
			px = render_pixel(w.line, w.column);
		return w.opcode == OP_RENDER;
	endfunction

	// Random command word, shaped so that renders land on tiles with written patterns.
	function automatic in_word_t random_word();
		in_word_t w;
		int pick;
		w.vram_address = 13'($urandom_range(0, VIDEO_BYTES - 1));
		w.write_data = 16'($urandom_range(0, 16'hFFFF));
		w.line = 8'($urandom_range(0, 255));
		w.column = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			w.opcode = OP_IGNORED;
		end else if (pick < 5) begin
			w.opcode = OP_SHADE3;
		end else if (pick < 50) begin
			w.opcode = OP_VRAM_WRITE;
			pick = $urandom_range(0, 3);
			if (pick == 1) begin
				w.vram_address = MAP_LOW + 13'($urandom_range(0, 2047));
				if ($urandom_range(0, 3) != 0)
					w.write_data[7:0] = HOT_TILES[$urandom_range(0, 4)];
			end else if (pick >= 2) begin
				w.vram_address = HOT_PATTERNS[$urandom_range(0, 7)] + 13'($urandom_range(0, 15));
			end
		end else begin
			// Mostly on screen, now and then below the last line or right of the edge.
			w.opcode = OP_RENDER;
			if ($urandom_range(0, 9) != 0)
				w.line = 8'($urandom_range(0, 143));
			else
				w.line = 8'($urandom_range(144, 255));
			if ($urandom_range(0, 9) != 0)
				w.column = 8'($urandom_range(0, SCREEN_WIDTH - 1));
			else
				w.column = 8'($urandom_range(SCREEN_WIDTH, 255));
		end
		return w;
	endfunction

	// Offers one word, with a random gap first, and records it once accepted.
	task automatic offer_word(input in_word_t w, input logic typed, input out_word_t want);
		out_word_t px;
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (apply_word(w, px))
			pending_pixels.push_back(typed ? want : px);
	endtask

	// Holds the input off until every pixel has arrived and the pipeline has emptied.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write, mirrored in the shadow registers.
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_LCD_CONTROL: lcd_ctl = val[7:0];
			CFG_SCROLL_X: scroll_h = val[7:0];
			CFG_SCROLL_Y: scroll_v = val[7:0];
			CFG_WINDOW_X: win_left = val[7:0];
			CFG_WINDOW_Y: win_top = val[7:0];
			CFG_SHADE0: shade_rgb[0] = val;
			CFG_SHADE1: shade_rgb[1] = val;
			CFG_SHADE2: shade_rgb[2] = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	// Register set for one random phase: the first takes every maximum, the last
	// zero scroll, window position and colours, the rest random values.
	task automatic program_phase(input int phase);
		logic [7:0] ctl;
		logic [7:0] sx;
		logic [7:0] sy;
		logic [7:0] wx;
		logic [7:0] wy;
		logic [15:0] c0;
		logic [15:0] c1;
		logic [15:0] c2;
		ctl = 8'($urandom_range(0, 255));
		if (!ctl[LCDC_BG_ON] && !ctl[LCDC_WIN_ON])
			ctl[LCDC_BG_ON] = 1'b1;
		sx = 8'($urandom_range(0, 255));
		sy = 8'($urandom_range(0, 255));
		wx = 8'($urandom_range(0, 175));
		wy = 8'($urandom_range(0, 160));
		c0 = 16'($urandom_range(0, 16'hFFFF));
		c1 = 16'($urandom_range(0, 16'hFFFF));
		c2 = 16'($urandom_range(0, 16'hFFFF));
		if (phase == 0) begin
			ctl = 8'hFF;
			sx = 8'hFF;
			sy = 8'hFF;
			wx = 8'hFF;
			wy = 8'hFF;
			c0 = 16'hFFFF;
			c1 = 16'hFFFF;
			c2 = 16'hFFFF;
		end else if (phase == PHASES - 1) begin
			ctl[LCDC_BG_ON] = 1'b1;
			ctl[LCDC_WIN_ON] = 1'b1;
			sx = 8'h00;
			sy = 8'h00;
			wx = 8'h00;
			wy = 8'h00;
			c0 = 16'h0000;
			c1 = 16'h0000;
			c2 = 16'h0000;
		end
		write_reg(CFG_LCD_CONTROL, {8'h00, ctl});
		write_reg(CFG_SCROLL_X, {8'h00, sx});
		write_reg(CFG_SCROLL_Y, {8'h00, sy});
		write_reg(CFG_WINDOW_X, {8'h00, wx});
		write_reg(CFG_WINDOW_Y, {8'h00, wy});
		write_reg(CFG_SHADE0, c0);
		write_reg(CFG_SHADE1, c1);
		write_reg(CFG_SHADE2, c2);
	endtask

	// Receiver: random stalls, plus a long hold whenever the stimulus asks for one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			holds_served <= 0;
		end else if (holds_served != hold_requests) begin
			holds_served <= hold_requests;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Each pixel word taken is compared with the oldest pending prediction.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel word arrived with no render pending");
				failures++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_word.shade_index !== want.shade_index) begin
					$error("shade_index mismatch: expected %0d, actual %0d",
						want.shade_index, out_word.shade_index);
					failures++;
				end
				if (out_word.pixel_color !== want.pixel_color) begin
					$error("pixel_color mismatch: expected %0d, actual %0d",
						want.pixel_color, out_word.pixel_color);
					failures++;
				end
				if (out_word.from_window !== want.from_window) begin
					$error("from_window mismatch: expected %0d, actual %0d",
						want.from_window, out_word.from_window);
					failures++;
				end
				if (out_word.drawn !== want.drawn) begin
					$error("drawn mismatch: expected %0d, actual %0d",
						want.drawn, out_word.drawn);
					failures++;
				end
			end
		end
	end

	// Stimulus: reset, the directed table, then the random phases.
	initial begin
		in_word_t w;
		int sent;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED_TABLE[i].kind == ROW_REG) begin
				wait_idle();
				write_reg(DIRECTED_TABLE[i].reg_idx, DIRECTED_TABLE[i].reg_val);
			end else begin
				offer_word(DIRECTED_TABLE[i].word, DIRECTED_TABLE[i].typed,
					DIRECTED_TABLE[i].want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			send_idle_pct = SEND_IDLE[phase];
			recv_stall_pct = RECV_STALL[phase];
			program_phase(phase);
			if (phase == PRESSURE_PHASE)
				hold_requests++;
			sent = 0;
			while (sent < PHASE_WORDS) begin
				// Halfway through, the sender waits for every pixel to come back.
				if (sent == PHASE_WORDS / 2) begin
					wait_idle();
					if (phase == PRESSURE_PHASE)
						hold_requests++;
				end
				w = random_word();
				offer_word(w, 1'b0, BLANK);
				if (w.opcode != OP_IGNORED)
					sent++;
			end
		end

		wait_idle();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#RUN_LIMIT_NS;
		$display("Test completed with failures");
		$finish;
	end

endmodule

### tile_background_window_pixel.f
+incdir+hdl
hdl/tbwp_pkg.sv
hdl/tbwp_ram.sv
hdl/tbwp_out_fifo.sv
hdl/tile_background_window_pixel.sv
verif/tb_tile_background_window_pixel.sv
